// File: sv/lpht_pkg.sv
package lpht_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int OP_W      = 2;
    localparam int KEY_W     = 31;
    localparam int STATUS_W  = 3;
    localparam int INDEX_W   = 4;
    localparam int MARK_W    = 2;

    // Home slot is (key mod MOD_BASE) mod SLOTS; a residue of MOD_BASE fits RES_BITS.
    localparam int MOD_BASE  = 1000;
    localparam int RES_BITS  = 10;
    // 2^RES_BITS is FOLD_MUL modulo MOD_BASE, so the bits above RES_BITS fold down.
    localparam int FOLD_MUL  = (1 << RES_BITS) - MOD_BASE;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  slot_index;
    } out_word_t;

endpackage

// File: sv/lpht_ram.sv
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/linear_probe_hash_table.sv
// Channel   Direction   Handshake            Word
// in        input       in_valid, in_stall   lpht_pkg::in_word_t   (operation, key)
// out       output      out_valid, out_stall lpht_pkg::out_word_t  (status, slot_index)
//
// Hashing folds the key down to key mod 1000, then one reciprocal multiply gives the
// remainder modulo SLOTS. The home slot is read, the probe goes on slot by slot
// (1 to SLOTS probed slots), and the output register is loaded last.
// After reset a clearing pass marks every slot empty; in_stall is high.
// in_stall stays high while an item is in progress; a result waiting in the output
// register does not block the next item until that item is finished.
module linear_probe_hash_table #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lpht_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output lpht_pkg::out_word_t out_word
);

    import lpht_pkg::*;

    localparam int SW       = $clog2(SLOTS);
    localparam int RECIP_SH = 2 * RES_BITS;
    // Rounded-up reciprocal of SLOTS; exact for every dividend below 2^RES_BITS.
    localparam int RECIP    = ((1 << RECIP_SH) + SLOTS - 1) / SLOTS;
    localparam int PROD_W   = RES_BITS + RECIP_SH;
    localparam int ENT_W    = MARK_W + KEY_W;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH_K = 7'b0000100,
        S_HASH_S = 7'b0001000,
        S_READ   = 7'b0010000,
        S_CHECK  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [SW-1:0]       s_reg, s_next;
    logic [SW-1:0]       n_reg, n_next;
    logic [KEY_W-1:0]    hash_reg, hash_next;
    logic [RES_BITS-1:0] quot_reg, quot_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SW-1:0]       res_slot_reg, res_slot_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_reg, out_next;

    logic [KEY_W-1:0]    fold_sum;
    logic [KEY_W-1:0]    unit_out;
    logic [PROD_W-1:0]   recip_prod;
    logic [PROD_W-1:0]   quot_prod;
    logic [RES_BITS-1:0] home_res;
    logic [SW-1:0]       s_wrap;
    logic                last_probe;
    logic [SW+INDEX_W-1:0] slot_ext;

    logic                wr_en;
    logic [SW-1:0]       wr_addr;
    logic [ENT_W-1:0]    wr_data;
    logic                rd_en;
    logic [SW-1:0]       rd_addr;
    logic [ENT_W-1:0]    rd_data;
    logic [MARK_W-1:0]   rd_mark;
    logic [KEY_W-1:0]    rd_key;

    // Each slot holds its mark above its key.
    lpht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_mark = rd_data[ENT_W-1:KEY_W];
    assign rd_key  = rd_data[KEY_W-1:0];

    // Shared reduction step: fold the bits above RES_BITS down, or take off MOD_BASE
    // once the value fits in RES_BITS. Each step keeps the value modulo MOD_BASE.
    assign fold_sum = KEY_W'(hash_reg[KEY_W-1:RES_BITS]) * KEY_W'(FOLD_MUL)
                    + KEY_W'(hash_reg[RES_BITS-1:0]);
    assign unit_out = (hash_reg[KEY_W-1:RES_BITS] != '0) ? fold_sum
                    : (hash_reg >= KEY_W'(MOD_BASE)) ? (hash_reg - KEY_W'(MOD_BASE))
                    : hash_reg;

    assign recip_prod = PROD_W'(hash_reg[RES_BITS-1:0]) * PROD_W'(RECIP);
    assign quot_prod  = PROD_W'(quot_reg) * PROD_W'(SLOTS);
    assign home_res   = hash_reg[RES_BITS-1:0] - quot_prod[RES_BITS-1:0];

    assign s_wrap     = (s_reg == SW'(SLOTS - 1)) ? '0 : (s_reg + 1'b1);
    assign last_probe = (n_reg == SW'(SLOTS - 1));
    assign slot_ext   = {{INDEX_W{1'b0}}, res_slot_reg};

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        s_next          = s_reg;
        n_next          = n_reg;
        hash_next       = hash_reg;
        quot_next       = quot_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        wr_en           = 1'b0;
        wr_addr         = s_reg;
        wr_data         = {MARK_EMPTY, key_reg};
        rd_en           = 1'b0;
        rd_addr         = s_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (s_reg == SW'(SLOTS - 1))
                begin
                    s_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_word.operation;
                    key_next   = in_word.key;
                    hash_next  = in_word.key;
                    state_next = S_HASH_K;
                end
            end
            S_HASH_K:
            begin
                hash_next = unit_out;
                if (unit_out < KEY_W'(MOD_BASE))
                begin
                    state_next = S_HASH_S;
                end
            end
            S_HASH_S:
            begin
                quot_next  = recip_prod[PROD_W-1:RECIP_SH];
                n_next     = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                s_next     = home_res[SW-1:0];
                rd_en      = 1'b1;
                rd_addr    = home_res[SW-1:0];
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next      = S_DONE;
                res_status_next = ST_MISSING;
                res_slot_next   = '0;
                if (op_reg == OP_INSERT)
                begin
                    if (rd_mark != MARK_USED)
                    begin
                        wr_en           = 1'b1;
                        wr_data         = {MARK_USED, key_reg};
                        res_status_next = ST_INSERTED;
                        res_slot_next   = s_reg;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else if (op_reg == OP_SEARCH || op_reg == OP_DELETE)
                begin
                    if (rd_mark == MARK_EMPTY)
                    begin
                        res_status_next = ST_MISSING;
                    end
                    else if (rd_mark == MARK_USED && rd_key == key_reg)
                    begin
                        res_slot_next = s_reg;
                        if (op_reg == OP_DELETE)
                        begin
                            wr_en           = 1'b1;
                            wr_data         = {MARK_GONE, rd_key};
                            res_status_next = ST_DELETED;
                        end
                        else
                        begin
                            res_status_next = ST_FOUND;
                        end
                    end
                    else if (!last_probe)
                    begin
                        state_next = S_CHECK;
                    end
                end
                // Moving on: read the next slot so its entry is ready next cycle.
                if (state_next == S_CHECK)
                begin
                    s_next  = s_wrap;
                    n_next  = n_reg + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = s_wrap;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    out_next.status     = res_status_reg;
                    out_next.slot_index = slot_ext[INDEX_W-1:0];
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        hash_reg       <= hash_next;
        quot_reg       <= quot_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_reg        <= out_next;
    end

endmodule

// File: verif/tb_linear_probe_hash_table.sv
`timescale 1ns / 100ps

module tb_linear_probe_hash_table;

    import lpht_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_PCT    = 31;
    localparam int DRAIN_WAIT  = 100;

    // The block ignores this code and answers not found.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_word;

    // Shadow copy of the table, updated as each word is accepted.
    logic [MARK_W-1:0] table_mark [SLOTS];
    logic [KEY_W-1:0]  table_key  [SLOTS];

    out_word_t   results_due [$];
    logic [KEY_W-1:0] recent_keys [$];
    out_word_t   want;
    logic        steady = 1'b0;
    int          hold_cycles = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          words_sent = 0;
    int          unused_sent = 0;
    int          results_seen = 0;
    int          status_tally [8];

    linear_probe_hash_table #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: a requested hold-off takes priority over the random stalls.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            status_tally[out_word.status]++;
            if (results_due.size() == 0)
            begin
                $error("unexpected result word: status %0d, slot_index %0d",
                       out_word.status, out_word.slot_index);
                error_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (out_word.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_word.status);
                    error_count++;
                end
                if (out_word.slot_index !== want.slot_index)
                begin
                    $error("slot_index: expected %0d, actual %0d",
                           want.slot_index, out_word.slot_index);
                    error_count++;
                end
            end
        end
    end

    function automatic out_word_t apply_table_op(in_word_t w);
        out_word_t   r;
        int unsigned s;
        r.status     = ST_MISSING;
        r.slot_index = '0;
        s = 32'(w.key);
        s = (s % MOD_BASE) % SLOTS;
        if (w.operation == OP_INSERT)
        begin
            r.status = ST_FULL;
            for (int n = 0; n < SLOTS; n++)
            begin
                if (table_mark[s] != MARK_USED)
                begin
                    table_mark[s] = MARK_USED;
                    table_key[s]  = w.key;
                    r.status      = ST_INSERTED;
                    r.slot_index  = s[INDEX_W-1:0];
                    break;
                end
                s = (s + 1) % SLOTS;
            end
        end
        else if (w.operation == OP_SEARCH || w.operation == OP_DELETE)
        begin
            for (int n = 0; n < SLOTS; n++)
            begin
                if (table_mark[s] == MARK_EMPTY)
                    break;
                if (table_mark[s] == MARK_USED && table_key[s] == w.key)
                begin
                    if (w.operation == OP_DELETE)
                    begin
                        table_mark[s] = MARK_GONE;
                        r.status      = ST_DELETED;
                    end
                    else
                    begin
                        r.status = ST_FOUND;
                    end
                    r.slot_index = s[INDEX_W-1:0];
                    break;
                end
                s = (s + 1) % SLOTS;
            end
        end
        return r;
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        in_word_t w;
        w.operation = op;
        w.key       = key;
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        results_due.push_back(apply_table_op(w));
        words_sent++;
        if (op == OP_UNUSED)
            unused_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    // Search and delete on an empty table stop at the home slot.
    task automatic test_empty_table();
        send_word(OP_SEARCH, 31'd0);
        send_word(OP_DELETE, 31'd999);
        drop_valid();
        wait_for_drain();
    endtask

    task automatic test_collisions_and_tombstones();
        send_word(OP_INSERT, 31'd0);
        send_word(OP_INSERT, 31'd1000);
        send_word(OP_INSERT, 31'h7FFF_FFFF);
        send_word(OP_INSERT, 31'd0);
        send_word(OP_SEARCH, 31'd1000);
        // The first copy goes; the search then has to probe past the tombstone.
        send_word(OP_DELETE, 31'd0);
        send_word(OP_SEARCH, 31'd0);
        send_word(OP_INSERT, 31'd16);
        send_word(OP_INSERT, 31'd15);
        // Home slot is the last one, so the probe wraps round to the start.
        send_word(OP_INSERT, 31'd31);
        drop_valid();
        wait_for_drain();
    endtask

    task automatic test_unused_opcode();
        send_word(OP_UNUSED, 31'd0);
        send_word(OP_UNUSED, 31'h7FFF_FFFF);
        drop_valid();
        wait_for_drain();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < 10; i++)
            send_word(OP_INSERT, 31'(2000 * i + 4));
        send_word(OP_INSERT, 31'd12345);
        send_word(OP_SEARCH, 31'd12345);
        send_word(OP_DELETE, 31'd54321);
        send_word(OP_DELETE, 31'd1000);
        drop_valid();
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        @(posedge clk);
        steady      = 1'b1;
        hold_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_word((i % 2) ? OP_SEARCH : OP_INSERT, 31'(7000 + 16 * (i / 2)));
        steady = 1'b0;
        drop_valid();
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        int               r;
        int               done_items;
        done_items = 0;
        while (done_items < n_items)
        begin
            steady = (done_items >= 500 && done_items < 800);
            r = $urandom_range(99);
            if (r < 3)
                op = OP_UNUSED;
            else if (r < 45)
                op = OP_INSERT;
            else if (r < 75)
                op = OP_SEARCH;
            else
                op = OP_DELETE;
            // Mostly keys already seen or keys crowding the same few home slots.
            r = $urandom_range(99);
            if (r < 45 && recent_keys.size() != 0)
                key = recent_keys[$urandom_range(recent_keys.size() - 1)];
            else if (r < 75)
                key = 31'(1000 * $urandom_range(2147482) + $urandom_range(20));
            else
                key = 31'($urandom());
            if (op == OP_INSERT)
            begin
                recent_keys.push_back(key);
                if (recent_keys.size() > 24)
                    void'(recent_keys.pop_front());
            end
            send_word(op, key);
            if (op != OP_UNUSED)
            begin
                done_items++;
                if (done_items % 300 == 0)
                begin
                    drop_valid();
                    wait_for_drain();
                end
            end
        end
        steady = 1'b0;
        drop_valid();
        wait_for_drain();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            table_mark[i] = MARK_EMPTY;
            table_key[i]  = '0;
        end
        foreach (status_tally[i])
            status_tally[i] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_collisions_and_tombstones();
        test_unused_opcode();
        test_full_table();
        test_backpressure();
        test_random_traffic(1370);

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Sent %0d input words (%0d with the unused opcode), checked %0d result words.",
                 words_sent, unused_sent, results_seen);
        $display("Results: inserted %0d, found %0d, deleted %0d, not found %0d, table full %0d.",
                 status_tally[ST_INSERTED], status_tally[ST_FOUND], status_tally[ST_DELETED],
                 status_tally[ST_MISSING], status_tally[ST_FULL]);
        if (error_count == 0 && results_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
sv/lpht_pkg.sv
sv/lpht_ram.sv
sv/linear_probe_hash_table.sv
verif/tb_linear_probe_hash_table.sv
